// ===== rtl/ssenum_pkg.sv =====
// Shared types and constants for the star subset enumerator.
`timescale 1ns / 1ps
`default_nettype none
package ssenum_pkg;

    // Field widths
    localparam int ID_W   = 31;
    localparam int MODE_W = 2;
    localparam int SIZE_W = 4;

    // Default list depth
    localparam int DEF_MAX_DEGREE = 8;

    // Smallest subset that is enumerated
    localparam int MIN_SUBSET = 3;

    // Request item modes
    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd2;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_ERR  = 4'b1000
    } t_state;

    // Commands to the position table
    typedef struct packed {
        logic clear;
        logic wr_en;
    } t_pos_cmd;

endpackage
`default_nettype wire

// ===== rtl/ssenum_req_if.sv =====
// Input channel: start, append and request items.
`timescale 1ns / 1ps
`default_nettype none
interface ssenum_req_if;
    import ssenum_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   center_node;
    logic [ID_W-1:0]   edge_id;

    modport source (output valid, output mode, output center_node, output edge_id,
                    input ready);
    modport sink   (input valid, input mode, input center_node, input edge_id,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/ssenum_res_if.sv =====
// Output channel: one subset element per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface ssenum_res_if;
    import ssenum_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [ID_W-1:0]   selected_edge;
    logic [SIZE_W-1:0] subset_size;
    logic              last_of_subset;
    logic              all_checked;
    logic [ID_W-1:0]   center_out;

    modport source (output valid, output status, output selected_edge,
                    output subset_size, output last_of_subset, output all_checked,
                    output center_out, input ready);
    modport sink   (input valid, input status, input selected_edge,
                    input subset_size, input last_of_subset, input all_checked,
                    input center_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssenum_pos.sv =====
// Position table with per-entry valid bits; an invalid entry reads as its index.
`timescale 1ns / 1ps
`default_nettype none
module ssenum_pos #(
    parameter int MAX_DEGREE = ssenum_pkg::DEF_MAX_DEGREE,
    parameter int PW         = $clog2(MAX_DEGREE)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssenum_pkg::t_pos_cmd i_cmd,
    input  logic [PW-1:0]        i_wr_addr,
    input  logic [PW-1:0]        i_wr_data,
    input  logic [PW-1:0]        i_rd_addr,
    output logic [PW-1:0]        o_rd_data
);
    import ssenum_pkg::*;

    logic [PW-1:0]         r_pos [MAX_DEGREE];
    logic [MAX_DEGREE-1:0] r_vld;

    // Valid bits: cleared by reset or a restart, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_pos[i_wr_addr] <= i_wr_data;
        end
    end

    // Read: identity until written
    assign o_rd_data = r_vld[i_rd_addr] ? r_pos[i_rd_addr] : i_rd_addr;

endmodule
`default_nettype wire

// ===== rtl/ssenum_edges.sv =====
// Incident edge register file, written in append order.
`timescale 1ns / 1ps
`default_nettype none
module ssenum_edges #(
    parameter int MAX_DEGREE = ssenum_pkg::DEF_MAX_DEGREE,
    parameter int PW         = $clog2(MAX_DEGREE)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [PW-1:0]             i_wr_addr,
    input  logic [ssenum_pkg::ID_W-1:0] i_wr_data,
    input  logic [PW-1:0]             i_rd_addr,
    output logic [ssenum_pkg::ID_W-1:0] o_rd_data
);
    import ssenum_pkg::*;

    logic [ID_W-1:0] r_mem [MAX_DEGREE];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port
    assign o_rd_data = r_mem[i_rd_addr];

endmodule
`default_nettype wire

// ===== rtl/star_subset_enumerator_top.sv =====
// Top level: sequencer for subset enumeration over one shared position compare unit.
// Start and append items are handled in the idle state; mode 3 items are accepted and dropped.
// A request of subset size k scans its k positions, then emits k element transfers,
// one per element, which stall under output backpressure.
// An empty or undersized request gives one error transfer.
// Synchronous active-low reset clears the sequencer, counts, flags and positions.
`timescale 1ns / 1ps
`default_nettype none
module star_subset_enumerator_top #(
    parameter int MAX_DEGREE = ssenum_pkg::DEF_MAX_DEGREE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ssenum_req_if.sink           i_req,
    ssenum_res_if.source         o_res
);
    import ssenum_pkg::*;

    localparam int PW = $clog2(MAX_DEGREE);
    localparam int CW = $clog2(MAX_DEGREE + 1);

    // Sequencer and enumeration state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_nd, n_nd;
    logic [CW-1:0]   r_sd, n_sd;
    logic            r_fin, n_fin;
    logic [ID_W-1:0] r_center, n_center;
    logic [PW-1:0]   r_idx, n_idx;
    logic [PW-1:0]   r_prev, n_prev;
    logic [PW-1:0]   r_cand, n_cand;
    logic [PW-1:0]   r_run, n_run;
    logic            r_found, n_found;
    logic            r_done, n_done;

    // Output register
    logic              r_ovalid, n_ovalid;
    logic              r_status, n_status;
    logic [ID_W-1:0]   r_edge, n_edge;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_last, n_last;
    logic              r_all, n_all;
    logic [ID_W-1:0]   r_cout, n_cout;

    // Submodule connections
    t_pos_cmd        pos_cmd;
    logic [PW-1:0]   pos_wdata;
    logic [PW-1:0]   cur;
    logic            edge_we;
    logic [ID_W-1:0] edge_rd;

    // Shared unit: incremented position and its compares
    logic [CW-1:0] cur_inc;
    logic [CW-1:0] prev_inc;
    logic          idx_last;
    logic          slot_free;
    logic          accept;

    assign cur_inc   = CW'(cur) + CW'(1);
    assign prev_inc  = CW'(r_prev) + CW'(1);
    assign idx_last  = (CW'(r_idx) + CW'(1)) == r_sd;
    assign slot_free = !r_ovalid || o_res.ready;
    assign accept    = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);

    ssenum_pos #(.MAX_DEGREE(MAX_DEGREE), .PW(PW)) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (pos_cmd),
        .i_wr_addr (r_idx),
        .i_wr_data (pos_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (cur)
    );

    ssenum_edges #(.MAX_DEGREE(MAX_DEGREE), .PW(PW)) u_edges (
        .i_clk     (i_clk),
        .i_wr_en   (edge_we),
        .i_wr_addr (r_nd[PW-1:0]),
        .i_wr_data (i_req.edge_id),
        .i_rd_addr (cur),
        .o_rd_data (edge_rd)
    );

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_nd      = r_nd;
        n_sd      = r_sd;
        n_fin     = r_fin;
        n_center  = r_center;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_cand    = r_cand;
        n_run     = r_run;
        n_found   = r_found;
        n_done    = r_done;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_status  = r_status;
        n_edge    = r_edge;
        n_size    = r_size;
        n_last    = r_last;
        n_all     = r_all;
        n_cout    = r_cout;
        pos_cmd   = '0;
        pos_wdata = '0;
        edge_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.mode == MODE_START) begin
                        n_center      = i_req.center_node;
                        n_nd          = '0;
                        n_sd          = '0;
                        n_fin         = 1'b0;
                        pos_cmd.clear = 1'b1;
                    end else if (i_req.mode == MODE_APPEND) begin
                        if (r_nd < CW'(MAX_DEGREE)) begin
                            edge_we = 1'b1;
                            n_nd    = r_nd + CW'(1);
                        end
                        n_sd          = n_nd;
                        n_fin         = 1'b0;
                        pos_cmd.clear = 1'b1;
                    end else if (i_req.mode == MODE_REQUEST) begin
                        n_idx   = '0;
                        n_found = 1'b0;
                        if (r_fin || r_sd < CW'(MIN_SUBSET)) begin
                            n_state = S_ERR;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Highest position with room to move wins
                if (r_idx != '0 && prev_inc < CW'(cur)) begin
                    n_found = 1'b1;
                    n_cand  = r_idx - PW'(1);
                end
                if (idx_last && cur_inc < r_nd) begin
                    n_found = 1'b1;
                    n_cand  = r_idx;
                end
                n_prev = cur;
                if (idx_last) begin
                    n_done  = !n_found && (r_sd == CW'(MIN_SUBSET));
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end

            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_status = STATUS_OK;
                    n_edge   = edge_rd;
                    n_size   = SIZE_W'(r_sd);
                    n_last   = idx_last;
                    n_all    = r_done;
                    n_cout   = r_center;
                    // Advance positions at the read pointer, from the candidate onward
                    if (r_found && r_idx >= r_cand) begin
                        pos_cmd.wr_en = 1'b1;
                        pos_wdata     = (r_idx == r_cand) ? cur_inc[PW-1:0]
                                                          : r_run + PW'(1);
                        n_run         = pos_wdata;
                    end
                    if (idx_last) begin
                        if (!r_found) begin
                            pos_cmd.clear = 1'b1;
                            n_sd          = r_sd - CW'(1);
                            n_fin         = r_done;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + PW'(1);
                    end
                end
            end

            S_ERR: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_status = STATUS_EMPTY;
                    n_edge   = '0;
                    n_size   = '0;
                    n_last   = 1'b1;
                    n_all    = 1'b1;
                    n_cout   = r_center;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nd     <= '0;
            r_sd     <= '0;
            r_fin    <= 1'b0;
            r_center <= '0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nd     <= n_nd;
            r_sd     <= n_sd;
            r_fin    <= n_fin;
            r_center <= n_center;
            r_found  <= n_found;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_cand   <= n_cand;
        r_run    <= n_run;
        r_status <= n_status;
        r_edge   <= n_edge;
        r_size   <= n_size;
        r_last   <= n_last;
        r_all    <= n_all;
        r_cout   <= n_cout;
    end

    // Result channel
    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_status;
    assign o_res.selected_edge  = r_edge;
    assign o_res.subset_size    = r_size;
    assign o_res.last_of_subset = r_last;
    assign o_res.all_checked    = r_all;
    assign o_res.center_out     = r_cout;

endmodule
`default_nettype wire
